### sv/assert_macros.svh
// Assertion macros shared by the RTL of the LRU stack depth tracker.
// Depends on nothing; the files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define LSDT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lru stack depth tracker check failed");

`define LSDT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("lru stack depth tracker forbidden condition");

`else

`define LSDT_ASSERT(label, clk, rst_n, prop)
`define LSDT_NEVER(label, clk, rst_n, expr)

`endif

`endif

### sv/lsdt_pkg.sv
// Shared constants and types of the LRU stack depth tracker.
// Depends on nothing; used by every module of the block.
package lsdt_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int PAGE_BITS   = 32;
    localparam int CAP_W       = 7;
    localparam int DEPTH_W     = 7;
    localparam int OCC_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef struct packed {
        logic step;
        logic valid;
    } cell_ctrl_t;

    typedef struct packed {
        logic match;
        logic found;
    } cell_stat_t;

endpackage

### sv/lru_stack_depth_tracker.sv
// LRU stack depth tracker: a row of cells holding distinct pages, most recent
// on top, answering each page request with hit and 1-based stack depth.
// Depends on lsdt_pkg, lsdt_cell, lsdt_depth_enc and assert_macros.svh.
//
// Usage:
//   Input channel (page, in_valid, in_stall) takes one page request.
//   Output channel (hit, depth, out_valid, out_stall) returns one result per
//   request, in request order; depth is 0 on a miss.
//   Configuration channel (cfg_data, cfg_valid, cfg_ready) writes capacity;
//   it is always ready and should be used only while no request is pending.
//   Every cell compares its page with the request in the same cycle and
//   shifts down when no match lies above it; the result is registered, and
//   a new request can be taken every cycle while in_stall is low.
//   The compare and the match ripple down the 64-cell row set the cycle time.
//   A two-entry output stage keeps taking requests while one result waits;
//   in_stall rises only when both entries are full because out_stall held.
//   Reset empties the stack, sets capacity to 64 and clears the output stage.
`include "assert_macros.svh"

module lru_stack_depth_tracker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lsdt_pkg::PAGE_BITS-1:0] page,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           hit,
    output logic [lsdt_pkg::DEPTH_W-1:0]   depth,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lsdt_pkg::CAP_W-1:0]     cfg_data
);

    localparam int N = lsdt_pkg::STACK_DEPTH;

    logic [lsdt_pkg::CAP_W-1:0]     capacity_reg;
    logic [lsdt_pkg::OCC_W-1:0]     occ_reg;
    logic [lsdt_pkg::OCC_W-1:0]     occ_next;
    logic [lsdt_pkg::OCC_W-1:0]     cap_eff;

    logic                           out_valid_reg;
    logic                           out_hit_reg;
    logic [lsdt_pkg::DEPTH_W-1:0]   out_depth_reg;
    logic                           skid_valid_reg;
    logic                           skid_hit_reg;
    logic [lsdt_pkg::DEPTH_W-1:0]   skid_depth_reg;

    logic                           accept;
    logic                           out_take;
    logic                           hit_now;
    logic [lsdt_pkg::DEPTH_W-1:0]   depth_now;
    logic [N-1:0]                   match_vec;
    logic [N:0]                     found_chain;
    logic [lsdt_pkg::PAGE_BITS-1:0] entry_w [N];
    lsdt_pkg::cell_stat_t           stat_w [N];
    lsdt_pkg::cell_ctrl_t           ctrl_w [N];

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign depth     = out_depth_reg;

    assign found_chain[0] = 1'b0;
    assign hit_now        = found_chain[N];

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            logic [lsdt_pkg::PAGE_BITS-1:0] above;

            if (gi == 0)
            begin : g_top
                assign above = page;
            end
            else
            begin : g_lower
                assign above = entry_w[gi-1];
            end

            assign ctrl_w[gi].step  = accept;
            assign ctrl_w[gi].valid = occ_reg > lsdt_pkg::OCC_W'(gi);

            lsdt_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl_w[gi]),
                .page        (page),
                .entry_above (above),
                .found_in    (found_chain[gi]),
                .entry       (entry_w[gi]),
                .stat        (stat_w[gi])
            );

            assign match_vec[gi]      = stat_w[gi].match;
            assign found_chain[gi+1]  = stat_w[gi].found;
        end
    endgenerate

    lsdt_depth_enc u_depth_enc (
        .match_vec (match_vec),
        .depth     (depth_now)
    );

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = lsdt_pkg::OCC_W'(1);
        end
        else if (lsdt_pkg::OCC_W'(capacity_reg) > lsdt_pkg::OCC_W'(N))
        begin
            cap_eff = lsdt_pkg::OCC_W'(N);
        end
        else
        begin
            cap_eff = lsdt_pkg::OCC_W'(capacity_reg);
        end

        if (hit_now)
        begin
            occ_next = (occ_reg > cap_eff) ? cap_eff : occ_reg;
        end
        else
        begin
            occ_next = (occ_reg >= cap_eff) ? cap_eff : occ_reg + lsdt_pkg::OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= lsdt_pkg::CAP_RESET;
            occ_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
            if (accept)
            begin
                occ_reg <= occ_next;
            end
            if (!out_valid_reg || out_take)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= accept;
                end
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_hit_reg   <= skid_hit_reg;
                out_depth_reg <= skid_depth_reg;
            end
            else
            begin
                out_hit_reg   <= hit_now;
                out_depth_reg <= depth_now;
            end
        end
        else if (accept)
        begin
            skid_hit_reg   <= hit_now;
            skid_depth_reg <= depth_now;
        end
    end

    `LSDT_ASSERT(a_occ_bound, clk, rst_n, occ_reg <= lsdt_pkg::OCC_W'(N))
    `LSDT_ASSERT(a_match_unique, clk, rst_n, $onehot0(match_vec))
    `LSDT_NEVER(a_skid_alone, clk, rst_n, skid_valid_reg && !out_valid_reg)
    `LSDT_ASSERT(a_push_fills, clk, rst_n, accept |=> occ_reg != '0)

endmodule

### sv/lsdt_cell.sv
// One stack cell: holds one page, compares it with the request and takes its
// upper neighbor's page when no match lies above it. Depends on lsdt_pkg.
module lsdt_cell (
    input  logic                           clk,
    input  lsdt_pkg::cell_ctrl_t           ctrl,
    input  logic [lsdt_pkg::PAGE_BITS-1:0] page,
    input  logic [lsdt_pkg::PAGE_BITS-1:0] entry_above,
    input  logic                           found_in,
    output logic [lsdt_pkg::PAGE_BITS-1:0] entry,
    output lsdt_pkg::cell_stat_t           stat
);

    logic [lsdt_pkg::PAGE_BITS-1:0] entry_reg;
    logic                           match;

    assign match      = ctrl.valid && (entry_reg == page);
    assign stat.match = match;
    assign stat.found = found_in | match;
    assign entry      = entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.step && !found_in)
        begin
            entry_reg <= entry_above;
        end
    end

endmodule

### sv/lsdt_depth_enc.sv
// Turns the one-hot match vector of the cell row into a 1-based depth.
// Depends on lsdt_pkg.
module lsdt_depth_enc (
    input  logic [lsdt_pkg::STACK_DEPTH-1:0] match_vec,
    output logic [lsdt_pkg::DEPTH_W-1:0]     depth
);

    always_comb
    begin
        depth = '0;
        for (int i = 0; i < lsdt_pkg::STACK_DEPTH; i++)
        begin
            if (match_vec[i])
            begin
                depth = depth | lsdt_pkg::DEPTH_W'(i + 1);
            end
        end
    end

endmodule

### test/tb_lru_stack_depth_tracker.sv
// Self-checking testbench for lru_stack_depth_tracker: page requests, capacity writes,
// random idling on both channels and a long output hold, checked against a shadow LRU stack.
// Depends on lsdt_pkg and the lru_stack_depth_tracker RTL.
module tb_lru_stack_depth_tracker;

    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic                         hit;
        logic [lsdt_pkg::DEPTH_W-1:0] depth;
    } lookup_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [lsdt_pkg::PAGE_BITS-1:0] page;
    logic                           out_valid;
    logic                           out_stall;
    logic                           hit;
    logic [lsdt_pkg::DEPTH_W-1:0]   depth;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [lsdt_pkg::CAP_W-1:0]     cfg_data;

    logic [lsdt_pkg::PAGE_BITS-1:0] shadow_stack [lsdt_pkg::STACK_DEPTH];
    int                             shadow_occ;
    logic [lsdt_pkg::CAP_W-1:0]     shadow_cap;
    lookup_t                        answer_q [$];
    int                             error_count;
    int                             quiet_cycles;
    int                             hold_req;
    int                             hold_left;
    int                             burst_left;
    bit                             tx_idle_en;
    bit                             rx_idle_en;

    lru_stack_depth_tracker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .page      (page),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .depth     (depth),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic lookup_t stack_reference(
        input logic [lsdt_pkg::PAGE_BITS-1:0] pg
    );
        lookup_t r;
        int      cap;
        int      n;
        int      pos;
        int      keep;
        bit      found;
        cap = int'(shadow_cap);
        if (cap < 1)
            cap = 1;
        if (cap > lsdt_pkg::STACK_DEPTH)
            cap = lsdt_pkg::STACK_DEPTH;
        n = shadow_occ;
        pos = 0;
        found = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (!found && shadow_stack[i] == pg)
            begin
                found = 1'b1;
                pos = i;
            end
        end
        if (found)
        begin
            for (int i = pos; i > 0; i--)
                shadow_stack[i] = shadow_stack[i-1];
            shadow_stack[0] = pg;
            shadow_occ = (n > cap) ? cap : n;
            r.hit = 1'b1;
            r.depth = lsdt_pkg::DEPTH_W'(pos + 1);
        end
        else
        begin
            keep = (n > cap - 1) ? cap - 1 : n;
            for (int i = keep; i > 0; i--)
                shadow_stack[i] = shadow_stack[i-1];
            shadow_stack[0] = pg;
            shadow_occ = keep + 1;
            r.hit = 1'b0;
            r.depth = '0;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            lookup_t want;
            bit      progress;
            progress = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                shadow_cap = cfg_data;
                progress = 1'b1;
            end
            if (in_valid && !in_stall)
            begin
                answer_q.push_back(stack_reference(page));
                progress = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                progress = 1'b1;
                if (answer_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("Unexpected result: hit=%0d depth=%0d", hit, depth);
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (hit !== want.hit || depth !== want.depth)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("Mismatch: expected hit=%0d depth=%0d, got hit=%0d depth=%0d",
                                     want.hit, want.depth, hit, depth);
                    end
                end
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL lru_stack_depth_tracker");
                $finish;
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        burst_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                out_stall <= 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                burst_left = $urandom_range(1, 9) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    function automatic logic [lsdt_pkg::PAGE_BITS-1:0] random_page();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return lsdt_pkg::PAGE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_page(input logic [lsdt_pkg::PAGE_BITS-1:0] pg);
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid <= 1'b1;
        page <= pg;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain_requests();
        in_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(input logic [lsdt_pkg::CAP_W-1:0] cap);
        drain_requests();
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_page(32'h0000_0000);
        send_page(32'hFFFF_FFFF);
        send_page(32'h0000_0000);
        send_page(32'h0000_0000);
        send_page(32'hFFFF_FFFF);
        send_page(32'h8000_0001);
        send_page(32'h7FFF_FFFE);
        send_page(32'h8000_0001);
        send_page(32'h0000_0000);
        // Capacity below occupancy: the deep entry still hits, then the stack is trimmed.
        write_capacity(lsdt_pkg::CAP_W'(2));
        send_page(32'hFFFF_FFFF);
        send_page(32'h7FFF_FFFE);
        write_capacity(lsdt_pkg::CAP_W'(1));
        send_page(32'h0000_0005);
        send_page(32'h0000_0005);
        send_page(32'h0000_0006);
        send_page(32'h0000_0005);
        write_capacity(lsdt_pkg::CAP_W'(0));
        send_page(32'h0000_0005);
        send_page(32'h0000_0005);
        send_page(32'h0000_0009);
        write_capacity(lsdt_pkg::CAP_W'(127));
        send_page(32'h0000_0001);
        send_page(32'h0000_0002);
        send_page(32'h0000_0001);
    endtask

    task automatic test_full_stack();
        logic [lsdt_pkg::PAGE_BITS-1:0] base;
        base = lsdt_pkg::PAGE_BITS'($urandom);
        write_capacity(lsdt_pkg::CAP_W'(64));
        for (int i = 0; i < lsdt_pkg::STACK_DEPTH; i++)
            send_page(base ^ lsdt_pkg::PAGE_BITS'(i * 32'h9E37_79B9));
        for (int i = 0; i < lsdt_pkg::STACK_DEPTH; i++)
            send_page(base ^ lsdt_pkg::PAGE_BITS'(i * 32'h9E37_79B9));
        send_page(~base);
        send_page(base ^ lsdt_pkg::PAGE_BITS'(32'h9E37_79B9));
    endtask

    task automatic test_shrink_below_occupancy();
        logic [lsdt_pkg::PAGE_BITS-1:0] list [40];
        write_capacity(lsdt_pkg::CAP_W'(64));
        foreach (list[i])
        begin
            list[i] = random_page();
            send_page(list[i]);
        end
        write_capacity(lsdt_pkg::CAP_W'(5));
        send_page(list[0]);
        send_page(list[1]);
        for (int i = 0; i < 10; i++)
            send_page(list[$urandom_range(0, 39)]);
    endtask

    task automatic test_output_hold();
        bit saved;
        saved = tx_idle_en;
        tx_idle_en = 1'b0;
        hold_req = 200;
        for (int i = 0; i < 30; i++)
            send_page(random_page());
        tx_idle_en = saved;
    endtask

    task automatic test_random_traffic(input logic [lsdt_pkg::CAP_W-1:0] cap,
                                       input int count);
        logic [lsdt_pkg::PAGE_BITS-1:0] pool [$];
        int                             eff;
        eff = (cap == 0) ? 1 :
              ((cap > lsdt_pkg::STACK_DEPTH) ? lsdt_pkg::STACK_DEPTH : int'(cap));
        write_capacity(cap);
        for (int i = 0; i < eff + eff / 4 + 1; i++)
            pool.push_back(random_page());
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 4) != 0)
                send_page(pool[$urandom_range(0, pool.size() - 1)]);
            else
                send_page(random_page());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        page = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        hold_req = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        error_count = 0;
        quiet_cycles = 0;
        shadow_occ = 0;
        shadow_cap = lsdt_pkg::CAP_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_full_stack();
        test_shrink_below_occupancy();
        test_output_hold();
        test_random_traffic(lsdt_pkg::CAP_W'(1), 110);
        test_random_traffic(lsdt_pkg::CAP_W'(2), 110);
        test_random_traffic(lsdt_pkg::CAP_W'(3), 110);
        test_random_traffic(lsdt_pkg::CAP_W'(8), 110);
        test_random_traffic(lsdt_pkg::CAP_W'(16), 110);
        test_random_traffic(lsdt_pkg::CAP_W'(31), 110);
        test_random_traffic(lsdt_pkg::CAP_W'(0), 110);
        test_random_traffic(lsdt_pkg::CAP_W'(127), 110);
        test_random_traffic(lsdt_pkg::CAP_W'(65), 110);
        test_random_traffic(lsdt_pkg::CAP_W'(48), 110);
        test_random_traffic(lsdt_pkg::CAP_W'($urandom_range(1, 64)), 110);
        test_random_traffic(lsdt_pkg::CAP_W'(64), 130);
        drain_requests();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_traffic(lsdt_pkg::CAP_W'(64), 130);

        drain_requests();
        repeat (5) @(negedge clk);
        error_count += answer_q.size();
        if (error_count == 0)
            $display("PASS lru_stack_depth_tracker");
        else
            $display("FAIL lru_stack_depth_tracker");
        $finish;
    end

endmodule
